// ===== rtl/sat_pkg.sv =====
// sat_pkg: shared types and constants of the section address translator
// holds the word layout, address kinds, controller states and the
// command/status structs between the controller and the datapath
`timescale 1ns / 1ps

package sat_pkg;

    // address kinds carried by source_kind and dest_kind
    typedef enum logic [1:0] {
        KIND_OFFSET   = 2'd0,
        KIND_RELATIVE = 2'd1,
        KIND_ABSOLUTE = 2'd2,
        KIND_INVALID  = 2'd3
    } t_kind;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BASE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 1'b1;
    localparam int CFG_DATA_W = 64;

    // field widths
    localparam int ENTRY_IDX_W = 6;
    localparam int SEC_W       = 32;
    localparam int ADDR_W      = 64;
    localparam int KIND_W      = 2;
    localparam int CNT_W       = 7;

    // input word layout, lowest bit first
    localparam int ENTRY_LSB = 0;
    localparam int VSTART_LSB = ENTRY_LSB + ENTRY_IDX_W;
    localparam int RSTART_LSB = VSTART_LSB + SEC_W;
    localparam int RSIZE_LSB  = RSTART_LSB + SEC_W;
    localparam int VSIZE_LSB  = RSIZE_LSB + SEC_W;
    localparam int ADDR_LSB   = VSIZE_LSB + SEC_W;
    localparam int SRC_LSB    = ADDR_LSB + ADDR_W;
    localparam int DST_LSB    = SRC_LSB + KIND_W;
    localparam int S_USED_W   = DST_LSB + KIND_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ADDR_W;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LIMITS,
        S_DECIDE,
        S_SEARCH,
        S_FIN_A,
        S_FIN_B,
        S_OUT
    } t_state;

    typedef struct packed {
        logic take;       // input word accepted this cycle
        logic scan_lim;   // limits pass over the table
        logic decide;     // resolve the special cases
        logic scan_find;  // first-match pass over the table
        logic fin_a;      // add the other start to the offset in section
        logic fin_b;      // add the image base when asked for
        logic out_load;   // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic pass_done;
        logic need_search;
        logic found;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/sat_ctrl.sv =====
// sat_ctrl: sequencer of the section address translator
// depends on sat_pkg for the state, command and status types
`timescale 1ns / 1ps

module sat_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    input  logic          i_s_axis_tuser,
    output logic          o_s_axis_tready,
    input  sat_pkg::t_sts i_sts,
    output sat_pkg::t_cmd o_cmd
);
    import sat_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.take = 1'b1;
                    // load words finish here, translate words start a run
                    if (i_s_axis_tuser) begin
                        n_state = S_LIMITS;
                    end
                end
            end
            S_LIMITS: begin
                o_cmd.scan_lim = 1'b1;
                if (i_sts.pass_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = i_sts.need_search ? S_SEARCH : S_OUT;
            end
            S_SEARCH: begin
                o_cmd.scan_find = 1'b1;
                if (i_sts.found) begin
                    n_state = S_FIN_A;
                end else if (i_sts.pass_done) begin
                    n_state = S_OUT;
                end
            end
            S_FIN_A: begin
                o_cmd.fin_a = 1'b1;
                n_state = S_FIN_B;
            end
            S_FIN_B: begin
                o_cmd.fin_b = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sat_datapath.sv =====
// sat_datapath: section table memory, limit and match logic, result register
// depends on sat_pkg; driven by sat_ctrl through t_cmd / t_sts
`timescale 1ns / 1ps

module sat_datapath #(
    parameter int MAX_SECTIONS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sat_pkg::t_cmd                       i_cmd,
    output sat_pkg::t_sts                       o_sts,
    input  logic [sat_pkg::S_TDATA_W-1:0]       i_s_axis_tdata,
    input  logic                                i_s_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [sat_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sat_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [sat_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    output logic                                o_m_axis_tuser
);
    import sat_pkg::*;

    localparam int IDX_W   = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int ENTRY_W = 4 * SEC_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SECTIONS);

    // input word fields
    logic [ENTRY_IDX_W-1:0] w_entry;
    logic [SEC_W-1:0]       w_vstart, w_rstart, w_rsize, w_vsize;
    logic [ADDR_W-1:0]      w_addr;
    t_kind                  w_src, w_dst;

    assign w_entry  = i_s_axis_tdata[ENTRY_LSB +: ENTRY_IDX_W];
    assign w_vstart = i_s_axis_tdata[VSTART_LSB +: SEC_W];
    assign w_rstart = i_s_axis_tdata[RSTART_LSB +: SEC_W];
    assign w_rsize  = i_s_axis_tdata[RSIZE_LSB +: SEC_W];
    assign w_vsize  = i_s_axis_tdata[VSIZE_LSB +: SEC_W];
    assign w_addr   = i_s_axis_tdata[ADDR_LSB +: ADDR_W];
    assign w_src    = t_kind'(i_s_axis_tdata[SRC_LSB +: KIND_W]);
    assign w_dst    = t_kind'(i_s_axis_tdata[DST_LSB +: KIND_W]);

    // configuration registers
    logic [ADDR_W-1:0] r_image_base;
    logic [CNT_W-1:0]  r_section_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_base    <= '0;
            r_section_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_BASE:    r_image_base    <= i_cfg_wdata;
                CFG_SECTION_COUNT: r_section_count <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0] w_live;
    assign w_live = (r_section_count > MAX_CNT) ? MAX_CNT : r_section_count;

    // section table: {virtual start, raw start, raw size, virtual size}
    logic [ENTRY_W-1:0] mem [MAX_SECTIONS];
    logic [ENTRY_W-1:0] r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_rdv;
    logic               w_rd_en;
    logic               w_wr_en;
    logic [IDX_W-1:0]   w_waddr;

    assign w_wr_en = i_cmd.take && !i_s_axis_tuser
                     && ({1'b0, w_entry} < MAX_CNT);
    assign w_waddr = IDX_W'(w_entry);
    assign w_rd_en = (i_cmd.scan_lim || i_cmd.scan_find) && (r_cnt < w_live);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_waddr] <= {w_vstart, w_rstart, w_rsize, w_vsize};
        end
        if (w_rd_en) begin
            r_rd <= mem[r_cnt[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rdv <= 1'b0;
        end else begin
            r_rdv <= w_rd_en;
            if (i_cmd.take || i_cmd.decide) begin
                r_cnt <= '0;
            end else if (w_rd_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    logic [SEC_W-1:0] w_e_vs, w_e_rs, w_e_rsz, w_e_vsz, w_span;
    assign {w_e_vs, w_e_rs, w_e_rsz, w_e_vsz} = r_rd;
    assign w_span = (w_e_rsz != '0) ? w_e_rsz : w_e_vsz;

    // item registers; an absolute source not asked for as absolute is
    // rebased to relative right at capture
    logic [ADDR_W-1:0] r_addr;
    t_kind             r_src, r_dst;
    logic              r_pre_fail;
    logic              w_rebase;

    assign w_rebase = (w_src == KIND_ABSOLUTE) && (w_dst != KIND_ABSOLUTE);

    // limits
    logic [ADDR_W-1:0] r_low;
    logic [SEC_W:0]    r_hi_rva, r_hi_off;
    logic [SEC_W:0]    w_vend_span, w_rend_span;

    assign w_vend_span = {1'b0, w_e_vs} + {1'b0, w_span};
    assign w_rend_span = {1'b0, w_e_rs} + {1'b0, w_span};

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_addr     <= w_rebase ? (w_addr - r_image_base) : w_addr;
            r_src      <= w_rebase ? KIND_RELATIVE : w_src;
            r_dst      <= w_dst;
            r_pre_fail <= w_rebase && (w_addr < r_image_base);
            r_low      <= '1;
            r_hi_rva   <= '0;
            r_hi_off   <= '0;
        end else if (i_cmd.scan_lim && r_rdv) begin
            if (ADDR_W'(w_e_vs) < r_low) begin
                r_low <= ADDR_W'(w_e_vs);
            end
            if (w_vend_span > r_hi_rva) begin
                r_hi_rva <= w_vend_span;
            end
            if (w_rend_span > r_hi_off) begin
                r_hi_off <= w_rend_span;
            end
        end
    end

    // special cases
    logic              w_need_search;
    logic              w_dec_ok;
    logic [ADDR_W-1:0] w_dec_res;

    always_comb begin
        w_need_search = 1'b0;
        w_dec_ok      = 1'b0;
        w_dec_res     = '0;
        if (r_pre_fail) begin
            w_dec_ok = 1'b0;
        end else if (r_src == r_dst) begin
            w_dec_ok  = 1'b1;
            w_dec_res = r_addr;
        end else begin
            case (r_src)
                KIND_OFFSET: begin
                    if ((r_addr < ADDR_W'(r_hi_off))
                        && (r_dst == KIND_RELATIVE || r_dst == KIND_ABSOLUTE)) begin
                        w_need_search = 1'b1;
                    end
                end
                KIND_RELATIVE: begin
                    if (r_addr < r_low) begin
                        // below every section: passes unchanged
                        w_dec_ok  = 1'b1;
                        w_dec_res = r_addr;
                    end else if (r_addr >= ADDR_W'(r_hi_rva)) begin
                        w_dec_ok = 1'b0;
                    end else if (r_dst == KIND_ABSOLUTE) begin
                        w_dec_ok  = 1'b1;
                        w_dec_res = r_image_base + r_addr;
                    end else if (r_dst == KIND_OFFSET) begin
                        w_need_search = 1'b1;
                    end
                end
                default: begin
                    w_dec_ok = 1'b0;
                end
            endcase
        end
    end

    // first-match search
    logic [SEC_W-1:0] w_m_base, w_m_other;
    logic [SEC_W:0]   w_m_end;
    logic             w_hit;
    logic             r_found;
    logic [SEC_W-1:0] r_other;
    logic [ADDR_W-1:0] r_res;
    logic             r_ok;

    always_comb begin
        if (r_src == KIND_OFFSET) begin
            w_m_base  = w_e_rs;
            w_m_other = w_e_vs;
            w_m_end   = {1'b0, w_e_rs} + {1'b0, w_span};
        end else begin
            w_m_base  = w_e_vs;
            w_m_other = w_e_rs;
            w_m_end   = {1'b0, w_e_vs} + {1'b0, w_e_vsz};
        end
    end

    assign w_hit = (r_addr >= ADDR_W'(w_m_base)) && (r_addr < ADDR_W'(w_m_end));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.take) begin
            r_found <= 1'b0;
        end else if (i_cmd.scan_find && r_rdv && !r_found && w_hit) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_ok  <= w_dec_ok;
            r_res <= w_dec_ok ? w_dec_res : '0;
        end else if (i_cmd.scan_find && r_rdv && !r_found && w_hit) begin
            r_res   <= r_addr - ADDR_W'(w_m_base);
            r_other <= w_m_other;
        end else if (i_cmd.fin_a) begin
            r_res <= r_res + ADDR_W'(r_other);
            r_ok  <= 1'b1;
        end else if (i_cmd.fin_b) begin
            if (r_src == KIND_OFFSET && r_dst == KIND_ABSOLUTE) begin
                r_res <= r_res + r_image_base;
            end
        end
    end

    // output register
    logic              r_ovalid;
    logic [ADDR_W-1:0] r_odata;
    logic              r_ook;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odata <= r_res;
            r_ook   <= r_ok;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ook;

    assign o_sts.pass_done   = !(r_cnt < w_live) && !r_rdv;
    assign o_sts.need_search = w_need_search;
    assign o_sts.found       = r_found;
    assign o_sts.out_free    = !r_ovalid || i_m_axis_tready;

endmodule

// ===== rtl/section_address_translator_unit.sv =====
// section_address_translator_unit: translates file offsets, relative and
// absolute virtual addresses through a table of up to MAX_SECTIONS sections.
// a load word is written to the table when it is taken; a translate word runs a limits pass over the
// n live sections, then a first-match search pass when needed, at one table read per cycle.
// one word is worked at a time, so no new word is taken before the last result is in the output register.
// reset (synchronous, active low) clears configuration, control and output valid; data registers and table undefined.
`timescale 1ns / 1ps

module section_address_translator_unit #(
    parameter int MAX_SECTIONS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave side
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // entry_index[5:0], sec_virtual_start[37:6], sec_raw_start[69:38],
    // sec_raw_size[101:70], sec_virtual_size[133:102], address[197:134],
    // source_kind[199:198], dest_kind[201:200], zero fill[207:202]
    input  logic [sat_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // req_type[0]
    input  logic                           i_s_axis_tuser,
    // master side
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // result_address[63:0]
    output logic [sat_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // ok[0]
    output logic                           o_m_axis_tuser,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [sat_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sat_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import sat_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    sat_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (w_sts),
        .o_cmd           (w_cmd)
    );

    sat_datapath #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

// ===== test/section_address_translator_unit_tb.sv =====
// section_address_translator_unit_tb: self-checking bench for the section address translator
// drives load and translate words on the stream input, predicts each result in the bench
// and checks it on the output; depends on sat_pkg and section_address_translator_unit
`timescale 1ns / 1ps

module section_address_translator_unit_tb;

    import sat_pkg::*;

    localparam int N_SECTIONS = 64;
    localparam int SETTLE_CYCLES = 2 * N_SECTIONS + 24;
    localparam int DRAIN_LIMIT = 20000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_XLATE = 1'b1;

    typedef struct {
        logic              req;
        logic [5:0]        idx;
        logic [31:0]       vstart;
        logic [31:0]       rstart;
        logic [31:0]       rsize;
        logic [31:0]       vsize;
        logic [63:0]       addr;
        t_kind             src;
        t_kind             dst;
    } t_sat_word;

    typedef struct packed {
        logic        ok;
        logic [63:0] addr;
    } t_xlate_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // bench copy of the block's registers and section table
    logic [63:0]  img_base = '0;
    logic [6:0]   sec_count = '0;
    logic [31:0]  vstart_tbl [N_SECTIONS];
    logic [31:0]  rstart_tbl [N_SECTIONS];
    logic [31:0]  rsize_tbl [N_SECTIONS];
    logic [31:0]  vsize_tbl [N_SECTIONS];

    t_xlate_result pending_results [$];
    int  fail_count = 0;
    bit  tx_jitter = 1'b1;
    bit  rx_jitter = 1'b1;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  stall_left = 0;

    section_address_translator_unit #(
        .MAX_SECTIONS(N_SECTIONS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic int live_sections();
        return (sec_count > N_SECTIONS) ? N_SECTIONS : int'(sec_count);
    endfunction

    // raw size, or the virtual size when the section has no raw data
    function automatic logic [63:0] section_span(input int i);
        return (rsize_tbl[i] != 0) ? 64'(rsize_tbl[i]) : 64'(vsize_tbl[i]);
    endfunction

    function automatic void predict_translation(input logic [63:0] addr_in, input t_kind src_in,
                                                input t_kind dst, output logic ok,
                                                output logic [63:0] res);
        logic [63:0] low_v, high_v, high_o, a, vs, rs, sz;
        t_kind src;
        int n, i;
        a = addr_in;
        src = src_in;
        ok = 1'b0;
        res = '0;
        low_v = '1;
        high_v = '0;
        high_o = '0;
        n = live_sections();
        if (src == dst) begin
            ok = 1'b1;
            res = a;
            return;
        end
        for (i = 0; i < n; i++) begin
            vs = 64'(vstart_tbl[i]);
            rs = 64'(rstart_tbl[i]);
            sz = section_span(i);
            if (vs < low_v) low_v = vs;
            if (vs + sz > high_v) high_v = vs + sz;
            if (rs + sz > high_o) high_o = rs + sz;
        end
        if (src == KIND_ABSOLUTE) begin
            if (a < img_base) return;
            a = a - img_base;
            src = KIND_RELATIVE;
            if (dst == KIND_RELATIVE) begin
                ok = 1'b1;
                res = a;
                return;
            end
        end
        if (src == KIND_OFFSET) begin
            if (a >= high_o) return;
            if (dst != KIND_RELATIVE && dst != KIND_ABSOLUTE) return;
            for (i = 0; i < n; i++) begin
                rs = 64'(rstart_tbl[i]);
                if (a >= rs && a < rs + section_span(i)) begin
                    res = 64'(vstart_tbl[i]) + (a - rs);
                    if (dst == KIND_ABSOLUTE) res = img_base + res;
                    ok = 1'b1;
                    return;
                end
            end
            return;
        end
        if (src == KIND_RELATIVE) begin
            // below every section the address maps to itself
            if (a < low_v) begin
                ok = 1'b1;
                res = a;
                return;
            end
            if (a >= high_v) return;
            if (dst == KIND_ABSOLUTE) begin
                ok = 1'b1;
                res = img_base + a;
                return;
            end
            if (dst != KIND_OFFSET) return;
            for (i = 0; i < n; i++) begin
                vs = 64'(vstart_tbl[i]);
                if (a >= vs && a < vs + 64'(vsize_tbl[i])) begin
                    ok = 1'b1;
                    res = 64'(rstart_tbl[i]) + (a - vs);
                    return;
                end
            end
        end
    endfunction

    // noise in every field the block should ignore for this word
    function automatic t_sat_word noise_word();
        t_sat_word w;
        w.req = REQ_XLATE;
        w.idx = 6'($urandom);
        w.vstart = $urandom;
        w.rstart = $urandom;
        w.rsize = $urandom;
        w.vsize = $urandom;
        w.addr = {$urandom, $urandom};
        w.src = t_kind'($urandom_range(0, 3));
        w.dst = t_kind'($urandom_range(0, 3));
        return w;
    endfunction

    function automatic t_sat_word section_word(input logic [5:0] idx, input logic [31:0] vs,
                                               input logic [31:0] rs, input logic [31:0] rsz,
                                               input logic [31:0] vsz);
        t_sat_word w;
        w = noise_word();
        w.req = REQ_LOAD;
        w.idx = idx;
        w.vstart = vs;
        w.rstart = rs;
        w.rsize = rsz;
        w.vsize = vsz;
        return w;
    endfunction

    function automatic t_sat_word random_section(input logic [5:0] idx);
        logic [31:0] rsz;
        if ($urandom_range(0, 3) == 0)
            return section_word(idx, $urandom, $urandom, $urandom, $urandom);
        rsz = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 32'h1_0000));
        return section_word(idx, {idx, 2'b00, 24'($urandom_range(0, 32'hFFFF))},
                            {idx, 2'b01, 24'($urandom_range(0, 32'hFFFF))},
                            rsz, 32'($urandom_range(0, 32'h1_0000)));
    endfunction

    function automatic logic [63:0] pick_address(input t_kind src);
        logic [63:0] base, span, rel;
        int n, j;
        n = live_sections();
        case ($urandom_range(0, 7))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(0, 4095));
            default: ;
        endcase
        if (n == 0) return {$urandom, $urandom};
        j = $urandom_range(0, n - 1);
        if (src == KIND_OFFSET) begin
            base = 64'(rstart_tbl[j]);
            span = section_span(j);
        end else begin
            base = 64'(vstart_tbl[j]);
            span = 64'(vsize_tbl[j]);
        end
        case ($urandom_range(0, 5))
            0: rel = base;
            1: rel = base + span;
            2: rel = base - 64'd1;
            default: rel = (span == 0) ? base : base + ({32'd0, $urandom} % span);
        endcase
        return (src == KIND_ABSOLUTE) ? img_base + rel : rel;
    endfunction

    function automatic t_sat_word random_translation();
        t_sat_word w;
        int pick;
        w = noise_word();
        pick = $urandom_range(0, 9);
        w.src = (pick < 4) ? KIND_OFFSET : (pick < 7) ? KIND_RELATIVE :
                (pick < 9) ? KIND_ABSOLUTE : KIND_INVALID;
        w.addr = pick_address(w.src);
        return w;
    endfunction

    task automatic send_word(input t_sat_word w);
        logic [S_TDATA_W-1:0] data;
        t_xlate_result r;
        data = '0;
        data[ENTRY_LSB +: ENTRY_IDX_W] = w.idx;
        data[VSTART_LSB +: SEC_W] = w.vstart;
        data[RSTART_LSB +: SEC_W] = w.rstart;
        data[RSIZE_LSB +: SEC_W] = w.rsize;
        data[VSIZE_LSB +: SEC_W] = w.vsize;
        data[ADDR_LSB +: ADDR_W] = w.addr;
        data[SRC_LSB +: KIND_W] = w.src;
        data[DST_LSB +: KIND_W] = w.dst;
        if (tx_jitter && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= w.req;
        do @(posedge i_clk); while (!s_tready);
        if (w.req == REQ_LOAD) begin
            vstart_tbl[w.idx] = w.vstart;
            rstart_tbl[w.idx] = w.rstart;
            rsize_tbl[w.idx] = w.rsize;
            vsize_tbl[w.idx] = w.vsize;
        end else begin
            predict_translation(w.addr, w.src, w.dst, r.ok, r.addr);
            pending_results = {pending_results, r};
        end
    endtask

    task automatic load_section(input logic [5:0] idx, input logic [31:0] vs,
                                input logic [31:0] rs, input logic [31:0] rsz,
                                input logic [31:0] vsz);
        send_word(section_word(idx, vs, rs, rsz, vsz));
    endtask

    task automatic translate(input logic [63:0] addr, input t_kind src, input t_kind dst);
        t_sat_word w;
        w = noise_word();
        w.addr = addr;
        w.src = src;
        w.dst = dst;
        send_word(w);
    endtask

    // stop offering words, let every result out and give a trailing load time to finish
    task automatic finish_pending();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        if (idx == CFG_IMAGE_BASE) img_base = data;
        else sec_count = data[6:0];
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_mix(input int n_words);
        repeat (n_words) begin
            if ($urandom_range(0, 4) == 0) send_word(random_section(6'($urandom)));
            else send_word(random_translation());
        end
    endtask

    task automatic test_empty_table();
        finish_pending();
        cfg_write(CFG_SECTION_COUNT, 64'd0);
        cfg_write(CFG_IMAGE_BASE, 64'h0000_0000_0040_0000);
        translate(64'd0, KIND_OFFSET, KIND_RELATIVE);
        translate('1, KIND_OFFSET, KIND_ABSOLUTE);
        translate(64'h1234, KIND_RELATIVE, KIND_OFFSET);
        translate('1, KIND_RELATIVE, KIND_ABSOLUTE);
        translate(64'h40_0005, KIND_ABSOLUTE, KIND_RELATIVE);
        translate(64'h3F_FFFF, KIND_ABSOLUTE, KIND_OFFSET);
        translate(64'h40_0010, KIND_ABSOLUTE, KIND_OFFSET);
        finish_pending();
    endtask

    task automatic test_known_layout();
        cfg_write(CFG_IMAGE_BASE, 64'h0000_0001_4000_0000);
        load_section(6'd0, 32'h1000, 32'h400, 32'h200, 32'h1000);
        // no raw data: the virtual size sets the limits and the file range
        load_section(6'd1, 32'h2000, 32'h600, 32'h0, 32'h800);
        load_section(6'd2, 32'hFFFF_F000, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // overlaps section 0 on both sides, first match must win
        load_section(6'd3, 32'h1800, 32'h400, 32'h100, 32'h100);
        finish_pending();
        cfg_write(CFG_SECTION_COUNT, 64'd4);
        translate(64'h450, KIND_OFFSET, KIND_RELATIVE);
        translate(64'h450, KIND_OFFSET, KIND_ABSOLUTE);
        translate(64'h600, KIND_OFFSET, KIND_RELATIVE);
        translate(64'h1_FFFF_FEFE, KIND_OFFSET, KIND_RELATIVE);
        translate(64'h1_FFFF_FEFF, KIND_OFFSET, KIND_RELATIVE);
        translate(64'h450, KIND_OFFSET, KIND_INVALID);
        translate(64'h300, KIND_OFFSET, KIND_RELATIVE);
        translate(64'h10, KIND_RELATIVE, KIND_OFFSET);
        translate(64'h10, KIND_RELATIVE, KIND_INVALID);
        translate(64'h1F00, KIND_RELATIVE, KIND_OFFSET);
        translate(64'h3000, KIND_RELATIVE, KIND_OFFSET);
        translate(64'h3000, KIND_RELATIVE, KIND_ABSOLUTE);
        translate('1, KIND_RELATIVE, KIND_OFFSET);
        translate(64'h0000_0001_4000_1050, KIND_ABSOLUTE, KIND_RELATIVE);
        translate(64'h0000_0001_4000_1800, KIND_ABSOLUTE, KIND_OFFSET);
        translate(64'h10, KIND_ABSOLUTE, KIND_OFFSET);
        translate(64'h1234, KIND_INVALID, KIND_RELATIVE);
        translate('1, KIND_INVALID, KIND_INVALID);
        translate(64'd0, KIND_OFFSET, KIND_OFFSET);
        translate('1, KIND_ABSOLUTE, KIND_ABSOLUTE);
        finish_pending();
    endtask

    task automatic test_base_extremes();
        cfg_write(CFG_IMAGE_BASE, '1);
        translate('1, KIND_ABSOLUTE, KIND_RELATIVE);
        translate('1, KIND_ABSOLUTE, KIND_OFFSET);
        translate(64'h450, KIND_OFFSET, KIND_ABSOLUTE);
        translate(64'h1050, KIND_RELATIVE, KIND_ABSOLUTE);
        finish_pending();
    endtask

    // every slot holds data before any count can reach it
    task automatic test_fill_table();
        for (int i = 0; i < N_SECTIONS; i++) send_word(random_section(6'(i)));
        finish_pending();
    endtask

    task automatic test_random_mix();
        logic [63:0] base_pick [4];
        logic [6:0] count_pick [5];
        base_pick = '{64'd0, '1, 64'h0000_0001_4000_0000, 64'd0};
        count_pick = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd0};
        for (int p = 0; p < 6; p++) begin
            finish_pending();
            base_pick[3] = {$urandom, $urandom};
            count_pick[4] = 7'($urandom_range(0, 127));
            cfg_write(CFG_IMAGE_BASE, base_pick[$urandom_range(0, 3)]);
            cfg_write(CFG_SECTION_COUNT, 64'((p < 4) ? count_pick[p] : count_pick[4]));
            tx_jitter = (p != 2) && ($urandom_range(0, 3) != 0);
            rx_jitter = (p != 2) && ($urandom_range(0, 3) != 0);
            random_mix(80);
        end
        finish_pending();
    endtask

    // output held off long enough that the block stops taking words
    task automatic test_backpressure();
        cfg_write(CFG_SECTION_COUNT, 64'd64);
        tx_jitter = 1'b0;
        hold_req = 1'b1;
        repeat (12) send_word(random_translation());
        finish_pending();
    endtask

    task automatic test_quiet_tail();
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        cfg_write(CFG_IMAGE_BASE, {$urandom, $urandom});
        cfg_write(CFG_SECTION_COUNT, 64'($urandom_range(1, 127)));
        random_mix(90);
        finish_pending();
    endtask

    // output side: stalls and result checking
    always @(posedge i_clk) begin
        t_xlate_result exp_r;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: ok %0b address %h", m_tuser, m_tdata);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tuser !== exp_r.ok) begin
                    $error("ok mismatch: expected %0b actual %0b", exp_r.ok, m_tuser);
                    fail_count++;
                end
                if (m_tdata !== exp_r.addr) begin
                    $error("result_address mismatch: expected %h actual %h", exp_r.addr, m_tdata);
                    fail_count++;
                end
            end
        end
        if (hold_req) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (rx_jitter && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_known_layout();
        test_base_extremes();
        test_fill_table();
        test_random_mix();
        test_backpressure();
        test_quiet_tail();
        if (pending_results.size() != 0) begin
            $error("%0d expected result words never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #7_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sat_pkg.sv
rtl/sat_ctrl.sv
rtl/sat_datapath.sv
rtl/section_address_translator_unit.sv
test/section_address_translator_unit_tb.sv
